/* src/b32_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32_pkg
// Shared types, constants and the character lookup of the base32 encoder.
// ----------------------------------------------------------------------------
package b32_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam int         QUEUE_DEPTH = 2;
  localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one request's worth of characters, as worked out by the front part
  typedef struct packed {
    logic [4:0] idx0;
    logic [4:0] idx1;
    logic [4:0] idx2;
    logic [1:0] n_alpha;
    logic [2:0] n_pad;
    logic       final_run;
  } b32_job_t;

  function automatic logic [7:0] alpha_char(input logic [4:0] idx);
    logic [7:0] c;
    if (idx < 5'd26) begin
      c = 8'h41 + {3'b000, idx};
    end else begin
      c = 8'h32 + {3'b000, idx - 5'd26};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/b32_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32_if
// Valid/ready channels for message bytes in and base32 characters out.
// ----------------------------------------------------------------------------
interface b32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output code_char, output run_end, output message_end,
                  input ready);
  modport sink   (input valid, input code_char, input run_end, input message_end,
                  output ready);
endinterface
`default_nettype wire

/* src/b32_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32_front
// Accepts bytes, runs the bit accumulator and group position, and describes
// the characters each request produces.
// ----------------------------------------------------------------------------
module b32_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  b32_in_if.sink                 in_ch,
  output b32_pkg::b32_job_t      job,
  output logic                   push,
  input  wire logic              full
);
  import b32_pkg::*;

  logic [3:0]  acc_r, acc_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [2:0]  gp_r, gp_nxt;

  logic [11:0] w;
  logic [11:0] t;
  logic [3:0]  h;
  logic [3:0]  sh;
  logic [3:0]  r;
  logic [4:0]  m5;
  logic        two;
  logic        lead;
  logic [1:0]  n_alpha;
  logic [2:0]  gp_sum;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    w       = {acc_r, in_ch.data_byte};
    h       = {1'b0, held_r} + 4'd8;
    sh      = 4'd12 - h;
    t       = w << sh;
    two     = (h >= 4'd10);
    r       = two ? (h - 4'd10) : (h - 4'd5);
    m5      = (5'd1 << r) - 5'd1;
    lead    = in_ch.final_byte && (r != 4'd0);
    n_alpha = (two ? 2'd2 : 2'd1) + {1'b0, lead};
    gp_sum  = gp_r + {1'b0, n_alpha};

    job.idx0      = t[11:7];
    job.idx1      = t[6:2];
    job.idx2      = {t[1:0], 3'b000};
    job.n_alpha   = n_alpha;
    job.n_pad     = in_ch.final_byte ? (3'd0 - gp_sum) : 3'd0;
    job.final_run = in_ch.final_byte;

    acc_nxt  = acc_r;
    held_nxt = held_r;
    gp_nxt   = gp_r;
    if (push) begin
      if (in_ch.final_byte) begin
        acc_nxt  = 4'd0;
        held_nxt = 3'd0;
        gp_nxt   = 3'd0;
      end else begin
        acc_nxt  = w[3:0] & m5[3:0];
        held_nxt = r[2:0];
        gp_nxt   = gp_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 4'd0;
      held_r <= 3'd0;
      gp_r   <= 3'd0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
      gp_r   <= gp_nxt;
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 3'd4) else $error("bit count out of range");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_ch.final_byte |=> (held_r == 3'd0) && (gp_r == 3'd0) && (acc_r == 4'd0))
    else $error("state not cleared after final byte");

  a_acc_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> held_r) == 4'd0) else $error("stale bits above held count");

endmodule
`default_nettype wire

/* src/b32_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32_queue
// Short queue of character runs between the front and back parts.
// ----------------------------------------------------------------------------
module b32_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire b32_pkg::b32_job_t job_in,
  output logic                   full,
  output logic                   job_valid,
  output b32_pkg::b32_job_t      job_out,
  input  wire logic              pop
);
  import b32_pkg::*;

  b32_job_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;

  assign full      = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign job_valid = (count_r != '0);
  assign job_out   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !job_valid)) else $error("pop from empty queue");

endmodule
`default_nettype wire

/* src/b32_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b32_back
// Walks the head run into the output register, one char per unstalled cycle.
// ----------------------------------------------------------------------------
module b32_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire b32_pkg::b32_job_t job,
  output logic                   pop,
  b32_out_if.source              out_ch
);
  import b32_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_run_end_r;
  logic       out_message_end_r;

  logic [3:0] total;
  logic       load;
  logic       emit;
  logic       last;
  logic [4:0] sel;
  logic [7:0] ch;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_char   = out_char_r;
  assign out_ch.run_end     = out_run_end_r;
  assign out_ch.message_end = out_message_end_r;

  always_comb begin
    total = {2'b00, job.n_alpha} + {1'b0, job.n_pad};
    load  = !out_valid_r || out_ch.ready;
    emit  = job_valid && load;
    last  = (pos_r == (total - 4'd1));
    pop   = emit && last;
    case (pos_r)
      4'd0:    sel = job.idx0;
      4'd1:    sel = job.idx1;
      default: sel = job.idx2;
    endcase
    ch      = (pos_r < {2'b00, job.n_alpha}) ? alpha_char(sel) : PAD_CHAR;
    pos_nxt = pos_r;
    if (emit) begin
      pos_nxt = last ? 4'd0 : (pos_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r        <= ch;
      out_run_end_r     <= last;
      out_message_end_r <= last && job.final_run;
    end
  end

  a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (pos_r < total)) else $error("position past end of run");

  a_msg_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_message_end_r |-> out_run_end_r)
    else $error("message end without run end");

endmodule
`default_nettype wire

/* src/base32_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base32_encoder
// Streaming base32 encoder: bytes in, alphabet and pad characters out.
// ----------------------------------------------------------------------------
// path: an accepted request is stored in the queue, then its characters pass
//   through the output register; throughput: one character per cycle while
//   the receiver is ready, set by the single output register; a byte yields
//   1 or 2 characters (up to 8 on a final byte), 8 characters per 5 bytes
// reset: synchronous active-low rst_n clears accumulator, queue and output
module base32_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  b32_in_if.sink    in_ch,
  b32_out_if.source out_ch
);
  import b32_pkg::*;

  b32_job_t front_job;
  b32_job_t head_job;
  logic     push;
  logic     full;
  logic     job_valid;
  logic     pop;

  b32_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .job   (front_job),
    .push  (push),
    .full  (full)
  );

  b32_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .job_in    (front_job),
    .full      (full),
    .job_valid (job_valid),
    .job_out   (head_job),
    .pop       (pop)
  );

  b32_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (head_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

/* bench/b32_char_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32_char_checker
// Watches both channels of the base32 encoder. Every accepted request is
// encoded by a local model of the encoder into the characters it should
// cause. Each accepted character is compared with the oldest one still due.
// ----------------------------------------------------------------------------
module b32_char_checker (
  input  logic clk,
  input  logic rst_n,
  b32_in_if    in_mon,
  b32_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  import b32_pkg::*;

  localparam logic [8*32-1:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  typedef struct packed {
    logic [7:0] code_char;
    logic       run_end;
    logic       message_end;
  } b32_char_t;

  b32_char_t   due_chars[$];
  logic [11:0] acc_bits;
  logic [3:0]  acc_count;
  logic [2:0]  group_pos;

  function automatic logic [7:0] alpha_of(input int idx);
    return ALPHABET[8*(31-idx) +: 8];
  endfunction

  function automatic void queue_char(input logic [7:0] c);
    b32_char_t ch;
    ch.code_char   = c;
    ch.run_end     = 1'b0;
    ch.message_end = 1'b0;
    due_chars.push_back(ch);
    group_pos = group_pos + 3'd1;
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic last);
    int acc;
    int held;
    int idx;
    acc  = ((int'(acc_bits) << 8) | int'(b)) & 'hFFF;
    held = int'(acc_count) + 8;
    while (held >= 5) begin
      idx  = (acc >> (held - 5)) & 'h1F;
      held = held - 5;
      queue_char(alpha_of(idx));
    end
    acc = acc & ((1 << held) - 1);
    if (last) begin
      // leftover bits padded with zeros on the right, then '=' to fill the group
      if (held > 0) begin
        idx = (acc << (5 - held)) & 'h1F;
        queue_char(alpha_of(idx));
      end
      while (group_pos != 3'd0) begin
        queue_char(PAD_CHAR);
      end
      acc  = 0;
      held = 0;
    end
    acc_bits  = acc[11:0];
    acc_count = held[3:0];
    due_chars[due_chars.size()-1].run_end     = 1'b1;
    due_chars[due_chars.size()-1].message_end = last;
  endtask

  always @(posedge clk) begin : watch
    b32_char_t want;
    if (!rst_n) begin
      due_chars.delete();
      acc_bits   = '0;
      acc_count  = '0;
      group_pos  = '0;
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        encode_byte(in_mon.data_byte, in_mon.final_byte);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_chars.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected char %h run_end %b message_end %b at %0t",
                     out_mon.code_char, out_mon.run_end, out_mon.message_end, $realtime);
          end
          fail_count++;
        end else begin
          want = due_chars.pop_front();
          if (out_mon.code_char !== want.code_char || out_mon.run_end !== want.run_end ||
              out_mon.message_end !== want.message_end) begin
            if (fail_count < 10) begin
              $display("mismatch at %0t: expected char %h run_end %b message_end %b, got %h %b %b",
                       $realtime, want.code_char, want.run_end, want.message_end,
                       out_mon.code_char, out_mon.run_end, out_mon.message_end);
            end
            fail_count++;
          end
        end
      end
    end
    pending = due_chars.size();
  end

endmodule

/* bench/tb_base32_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base32_encoder
// Drives messages of bytes into the base32 encoder: a directed set covering
// every remainder and pad count, then random messages. The sender works in
// bursts with gaps, the receiver stalls in changing patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_base32_encoder;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 100;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   burst_left;
  int   items_sent;
  logic [7:0] msg_bytes[$];

  b32_in_if  in_ch();
  b32_out_if out_ch();

  base32_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b32_char_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: the ready pattern switches between four randomly chosen modes
  initial begin : receiver
    int mode;
    int span;
    int k;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_ch.ready = 1'b1;
          end
          1: begin
            out_ch.ready = 1'($urandom_range(0, 1));
          end
          2: begin
            out_ch.ready = (k % 4 == 0);
          end
          default: begin
            out_ch.ready = ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid      = 1'b1;
    in_ch.data_byte  = b;
    in_ch.final_byte = last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_msg();
    int i;
    for (i = 0; i < msg_bytes.size(); i++) begin
      push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  initial begin : stimulus
    int len;
    int i;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    burst_left       = 0;
    items_sent       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // one to six bytes: every leftover width and pad count
    msg_bytes = '{8'hFF};
    send_msg();
    msg_bytes = '{8'h00, 8'hFF};
    send_msg();
    msg_bytes = '{8'h55, 8'hAA, 8'h80};
    send_msg();
    msg_bytes = '{8'h01, 8'hFE, 8'h7F, 8'hFF};
    send_msg();
    msg_bytes = '{8'h00, 8'h00, 8'hFF, 8'hF0, 8'h0F};
    send_msg();
    msg_bytes = '{8'h00};
    send_msg();
    msg_bytes = '{8'hF8, 8'h3E, 8'h0F, 8'h83, 8'hE0, 8'hFF};
    send_msg();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 12);
      msg_bytes.delete();
      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       msg_bytes.push_back(8'h00);
          1:       msg_bytes.push_back(8'hFF);
          default: msg_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      send_msg();
    end
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
